// ===== rtl/dst_pkg.sv =====
// Package for the decaying score table: beat payload types, register codes,
// the Q1.16 fractional decay table and the controller/datapath command structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dst_pkg;

  localparam int unsigned CfgAddrBits = 3;
  localparam logic [CfgAddrBits-1:0] AddrHalfLife = 3'd0;
  localparam logic [CfgAddrBits-1:0] AddrIncrement = 3'd4;

  localparam logic [31:0] HalfLifeReset = 32'd604800;
  localparam logic [15:0] IncrementReset = 16'd4096;

  localparam logic [1:0] OutcomeHit = 2'd0;
  localparam logic [1:0] OutcomeAppend = 2'd1;
  localparam logic [1:0] OutcomeEvict = 2'd2;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] now_seconds;
  } in_beat_t;

  typedef struct packed {
    logic [8:0]  slot;
    logic [1:0]  outcome;
    logic [31:0] new_score;
  } out_beat_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic capture;     // latch input beat
    logic rd_en;       // issue read of tables at rd_addr
    logic dec_start;   // start decay of returned entry
    logic min_take;    // compare decayed value against running minimum
    logic min_first;   // first entry of the min sweep
    logic fin_start;   // start final decay of the hit entry
    logic write;       // commit the selected slot
    logic load_out;    // load the output register
  } dst_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic key_match;
    logic dec_done;
  } dst_sts_t;

  // F[i] = round(2^16 * 2^(-i/256))
  function automatic logic [16:0] frac_rom(input logic [7:0] idx);
    logic [63:0] a;
    logic [63:0] f;
    a = 64'd1 << 32;
    f = 64'd65536;
    for (int i = 1; i < 256; i++) begin
      a = (a * 64'd4283353945 + (64'd1 << 31)) >> 32;
      if (i == int'(idx)) f = (a + 64'd32768) >> 16;
    end
    return f[16:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dst_ram.sv =====
// Generic single-port RAM with registered read, used for the entry tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module dst_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/dst_datapath.sv =====
// Datapath: entry tables, serial decay unit (restoring divide + table multiply),
// running minimum and output register. Depends on dst_pkg and dst_ram.
`timescale 1ns / 1ps
`default_nettype none
module dst_datapath #(
  parameter int unsigned Entries = 512,
  parameter int unsigned KeyBits = 64,
  parameter int unsigned ScoreBits = 32,
  localparam int unsigned AddrBits = $clog2(Entries)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dst_pkg::dst_cmd_t  cmd_i,
  input  wire logic [AddrBits-1:0] rd_addr_i,
  input  wire logic [AddrBits-1:0] wr_addr_i,
  input  wire logic [1:0]         outcome_i,
  input  wire dst_pkg::in_beat_t  in_beat_i,
  input  wire logic [31:0]        decay_period_i,
  input  wire logic [15:0]        increment_i,
  output dst_pkg::dst_sts_t       sts_o,
  output logic [AddrBits-1:0]     min_slot_o,
  output dst_pkg::out_beat_t      out_beat_o
);
  logic [KeyBits-1:0]   key_q;
  logic [31:0]          now_q;
  logic [KeyBits-1:0]   key_rd;
  logic [ScoreBits-1:0] score_rd;
  logic [31:0]          time_rd;
  logic [AddrBits-1:0]  addr;
  logic                 we;
  logic [ScoreBits-1:0] score_wr;

  assign we   = cmd_i.write;
  assign addr = we ? wr_addr_i : rd_addr_i;

  dst_ram #(.Width(KeyBits), .Depth(Entries)) u_keys (
    .clk_i, .we_i(we), .re_i(cmd_i.rd_en), .addr_i(addr),
    .wdata_i(key_q), .rdata_o(key_rd));
  dst_ram #(.Width(ScoreBits), .Depth(Entries)) u_scores (
    .clk_i, .we_i(we), .re_i(cmd_i.rd_en), .addr_i(addr),
    .wdata_i(score_wr), .rdata_o(score_rd));
  dst_ram #(.Width(32), .Depth(Entries)) u_times (
    .clk_i, .we_i(we), .re_i(cmd_i.rd_en), .addr_i(addr),
    .wdata_i(now_q), .rdata_o(time_rd));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      key_q <= in_beat_i.key[KeyBits-1:0];
      now_q <= in_beat_i.now_seconds;
    end
  end

  assign sts_o.key_match = (key_rd == key_q);

  // Decay unit. Phases: 32 divide steps of elapsed by H, 8 steps for the
  // table index (r*256/H), one shift, one multiply.
  localparam logic [2:0] DecIdle = 3'd0;
  localparam logic [2:0] DecDiv  = 3'd1;
  localparam logic [2:0] DecFrac = 3'd2;
  localparam logic [2:0] DecShift = 3'd3;
  localparam logic [2:0] DecMul  = 3'd4;
  localparam logic [2:0] DecDone = 3'd5;

  logic [2:0]           dec_st_q, dec_st_d;
  logic [5:0]           dcnt_q, dcnt_d;
  logic [31:0]          quo_q, quo_d;      // dividend bits shift out, quotient in
  logic [32:0]          rem_q, rem_d;
  logic [7:0]           idx_q, idx_d;
  logic [ScoreBits-1:0] sc_q, sc_d;
  logic                 zero_q, zero_d;    // decays to zero
  logic                 keep_q, keep_d;    // no decay
  logic [ScoreBits+16:0] prod;
  logic [32:0]          rsh;
  logic [32:0]          elapsed;
  logic [ScoreBits-1:0] dec_val;

  assign elapsed = {1'b0, now_q} - {1'b0, time_rd};
  assign rsh     = {rem_q[31:0], quo_q[31]};
  assign prod    = sc_q * dst_pkg::frac_rom(idx_q);

  always_comb begin
    dec_st_d = dec_st_q;
    dcnt_d = dcnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    idx_d = idx_q;
    sc_d = sc_q;
    zero_d = zero_q;
    keep_d = keep_q;
    case (dec_st_q)
      DecIdle: begin
        if (cmd_i.dec_start || cmd_i.fin_start) begin
          sc_d = score_rd;
          quo_d = elapsed[31:0];
          rem_d = '0;
          dcnt_d = '0;
          idx_d = '0;
          keep_d = elapsed[32] || (elapsed[31:0] == 32'd0);
          zero_d = (decay_period_i == 32'd0);
          dec_st_d = DecDiv;
        end
      end
      DecDiv: begin
        quo_d = {quo_q[30:0], 1'b0};
        rem_d = rsh;
        if (rsh >= {1'b0, decay_period_i}) begin
          rem_d = rsh - {1'b0, decay_period_i};
          quo_d[0] = 1'b1;
        end
        dcnt_d = dcnt_q + 6'd1;
        if (dcnt_q == 6'd31) begin
          dcnt_d = '0;
          dec_st_d = DecFrac;
        end
      end
      DecFrac: begin
        rem_d = {rem_q[31:0], 1'b0};
        idx_d = {idx_q[6:0], 1'b0};
        if ({rem_q[31:0], 1'b0} >= {1'b0, decay_period_i}) begin
          rem_d = {rem_q[31:0], 1'b0} - {1'b0, decay_period_i};
          idx_d[0] = 1'b1;
        end
        dcnt_d = dcnt_q + 6'd1;
        if (dcnt_q == 6'd7) dec_st_d = DecShift;
      end
      DecShift: begin
        if (quo_q >= 32'd64) zero_d = 1'b1;
        else sc_d = sc_q >> quo_q[5:0];
        dec_st_d = DecMul;
      end
      DecMul: begin
        sc_d = prod[ScoreBits+15:16];
        dec_st_d = DecDone;
      end
      DecDone: dec_st_d = DecIdle;
      default: dec_st_d = DecIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dec_st_q <= DecIdle;
    else dec_st_q <= dec_st_d;
  end

  always_ff @(posedge clk_i) begin
    dcnt_q <= dcnt_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    idx_q <= idx_d;
    sc_q <= sc_d;
    zero_q <= zero_d;
    keep_q <= keep_d;
  end

  // keep returns the original score: sc_q has been shifted and scaled, so use the copy
  logic [ScoreBits-1:0] orig_q;
  always_ff @(posedge clk_i) begin
    if (dec_st_q == DecIdle) orig_q <= score_rd;
  end

  assign dec_val = keep_q ? orig_q : (zero_q ? '0 : sc_q);
  assign sts_o.dec_done = (dec_st_q == DecDone);

  // Running minimum: strict less-than keeps the lowest index
  logic [ScoreBits-1:0] min_q;
  logic [AddrBits-1:0]  min_slot_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.min_take && (cmd_i.min_first || dec_val < min_q)) begin
      min_q <= dec_val;
      min_slot_q <= rd_addr_i;
    end
  end
  assign min_slot_o = min_slot_q;

  // Base is the decayed hit score, zero otherwise
  logic [ScoreBits:0] sum;
  assign sum = (outcome_i == dst_pkg::OutcomeHit) ?
               {1'b0, dec_val} + (ScoreBits+1)'(increment_i) :
               (ScoreBits+1)'(increment_i);
  assign score_wr = sum[ScoreBits] ? '1 : sum[ScoreBits-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_beat_o.slot <= 9'(wr_addr_i);
      out_beat_o.outcome <= outcome_i;
      out_beat_o.new_score <= 32'(score_wr);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/dst_ctrl.sv =====
// Controller: sweeps the table for a key, on a full-table miss for the lowest
// decayed score, and sequences the decay unit and commit. Depends on dst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dst_ctrl #(
  parameter int unsigned Entries = 512,
  localparam int unsigned AddrBits = $clog2(Entries),
  localparam int unsigned CountBits = $clog2(Entries + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire dst_pkg::dst_sts_t   sts_i,
  input  wire logic [AddrBits-1:0] min_slot_i,
  output dst_pkg::dst_cmd_t        cmd_o,
  output logic [AddrBits-1:0]      rd_addr_o,
  output logic [AddrBits-1:0]      wr_addr_o,
  output logic [1:0]               outcome_o
);
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StLook  = 3'd1;
  localparam logic [2:0] StCheck = 3'd2;
  localparam logic [2:0] StMinRd = 3'd3;
  localparam logic [2:0] StMinDec = 3'd4;
  localparam logic [2:0] StHitDec = 3'd5;
  localparam logic [2:0] StCommit = 3'd6;

  logic [2:0]           st_q, st_d;
  logic [CountBits-1:0] count_q, count_d;
  logic [AddrBits-1:0]  ptr_q, ptr_d;
  logic [AddrBits-1:0]  slot_q, slot_d;
  logic [1:0]           oc_q, oc_d;
  logic                 first_q, first_d;
  logic                 ov_q, ov_d;

  // Output register frees once taken; next beat can be accepted meanwhile
  assign in_ready_o  = (st_q == StIdle) && (!ov_q || out_ready_i);
  assign out_valid_o = ov_q;
  assign rd_addr_o   = ptr_q;
  assign wr_addr_o   = slot_q;
  assign outcome_o   = oc_q;

  logic last;
  assign last = (CountBits'(ptr_q) == count_q - CountBits'(1));

  always_comb begin
    st_d = st_q;
    count_d = count_q;
    ptr_d = ptr_q;
    slot_d = slot_q;
    oc_d = oc_q;
    first_d = first_q;
    ov_d = ov_q && !out_ready_i;
    cmd_o = '0;
    case (st_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.capture = 1'b1;
          ptr_d = '0;
          if (count_q == '0) begin
            slot_d = '0;
            oc_d = dst_pkg::OutcomeAppend;
            st_d = StCommit;
          end else st_d = StLook;
        end
      end
      StLook: begin
        cmd_o.rd_en = 1'b1;
        st_d = StCheck;
      end
      StCheck: begin
        if (sts_i.key_match) begin
          slot_d = ptr_q;
          oc_d = dst_pkg::OutcomeHit;
          st_d = StHitDec;
          cmd_o.fin_start = 1'b1;
        end else if (!last) begin
          ptr_d = ptr_q + AddrBits'(1);
          st_d = StLook;
        end else if (count_q < CountBits'(Entries)) begin
          slot_d = count_q[AddrBits-1:0];
          oc_d = dst_pkg::OutcomeAppend;
          st_d = StCommit;
        end else begin
          ptr_d = '0;
          first_d = 1'b1;
          oc_d = dst_pkg::OutcomeEvict;
          st_d = StMinRd;
        end
      end
      StMinRd: begin
        cmd_o.rd_en = 1'b1;
        st_d = StMinDec;
      end
      StMinDec: begin
        if (first_q || sts_i.dec_done) cmd_o.dec_start = first_q;
        if (sts_i.dec_done) begin
          cmd_o.min_take = 1'b1;
          cmd_o.min_first = (ptr_q == '0);
          if (last) begin
            st_d = StCommit;
            first_d = 1'b0;
          end else begin
            ptr_d = ptr_q + AddrBits'(1);
            first_d = 1'b1;
            st_d = StMinRd;
          end
        end else first_d = 1'b0;
      end
      StHitDec: begin
        if (sts_i.dec_done) st_d = StCommit;
      end
      StCommit: begin
        if (oc_q == dst_pkg::OutcomeEvict) slot_d = min_slot_i;
        if (oc_q != dst_pkg::OutcomeEvict || slot_q == min_slot_i) begin
          cmd_o.write = 1'b1;
          cmd_o.load_out = 1'b1;
          ov_d = 1'b1;
          if (oc_q == dst_pkg::OutcomeAppend) count_d = count_q + CountBits'(1);
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      count_q <= '0;
      ov_q <= 1'b0;
      first_q <= 1'b0;
    end else begin
      st_q <= st_d;
      count_q <= count_d;
      ov_q <= ov_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    slot_q <= slot_d;
    oc_q <= oc_d;
  end
endmodule
`default_nettype wire

// ===== rtl/decaying_score_table.sv =====
// Decaying score table top level: APB register file, controller and datapath.
// Depends on dst_pkg, dst_ctrl, dst_datapath, dst_ram.
//
// Launch events carry a key and a time; each produces one result beat with the
// updated slot, the outcome (hit, append, evict) and the new Q20.12 score.
// The table is searched one entry at a time (a read, then a key compare), and a
// hit adds one decay of the stored score. When the table is full a miss also
// walks every entry through the serial decay unit (divider plus fraction
// multiply). A new launch is accepted only once the previous one has committed.
// Stored entries hold no reset value; the fill count tracks valid entries, so
// no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none
module decaying_score_table #(
  parameter int unsigned ENTRIES = 512,
  parameter int unsigned KEY_BITS = 64,
  parameter int unsigned SCORE_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire dst_pkg::in_beat_t     in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output dst_pkg::out_beat_t         out_data_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [dst_pkg::CfgAddrBits-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  localparam int unsigned AddrBits = $clog2(ENTRIES);

  logic [31:0] decay_period_q;
  logic [15:0] increment_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_period_q <= dst_pkg::HalfLifeReset;
      increment_q <= dst_pkg::IncrementReset;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        dst_pkg::AddrHalfLife:  decay_period_q <= pwdata;
        dst_pkg::AddrIncrement: increment_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      dst_pkg::AddrHalfLife:  prdata = decay_period_q;
      dst_pkg::AddrIncrement: prdata = {16'd0, increment_q};
      default:                prdata = '0;
    endcase
  end

  dst_pkg::dst_cmd_t  cmd;
  dst_pkg::dst_sts_t  sts;
  logic [AddrBits-1:0] rd_addr, wr_addr, min_slot;
  logic [1:0]          outcome;

  dst_ctrl #(.Entries(ENTRIES)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .min_slot_i(min_slot), .cmd_o(cmd), .rd_addr_o(rd_addr),
    .wr_addr_o(wr_addr), .outcome_o(outcome));

  dst_datapath #(.Entries(ENTRIES), .KeyBits(KEY_BITS), .ScoreBits(SCORE_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .rd_addr_i(rd_addr), .wr_addr_i(wr_addr),
    .outcome_i(outcome), .in_beat_i(in_data_i), .decay_period_i(decay_period_q),
    .increment_i(increment_q), .sts_o(sts), .min_slot_o(min_slot),
    .out_beat_o(out_data_o));

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en |-> !in_ready_o) else $error("input accepted during a sweep");
  a_write_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.write |=> out_valid_o) else $error("commit without result beat");
  a_single_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.write && cmd.rd_en)) else $error("table read and write together");
endmodule
`default_nettype wire

// ===== tb/dst_score_checker.sv =====
// Checker for the decaying score table: snoops the launch, result and APB buses,
// keeps its own copy of the table and registers, and checks every result beat.
// Depends on dst_pkg.
`timescale 1ns / 1ps
module dst_score_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  dst_pkg::in_beat_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  dst_pkg::out_beat_t out_data_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [dst_pkg::CfgAddrBits-1:0] paddr_i,
  input  logic [31:0]        pwdata_i,
  input  logic               pready_i,
  output int                 pending_o,
  output int                 failures_o
);
  localparam int TableDepth = 512;
  localparam logic [31:0] ScoreMax = 32'hFFFF_FFFF;

  logic [16:0] decay_frac [256];
  logic [63:0] tbl_key [TableDepth];
  logic [31:0] tbl_score [TableDepth];
  logic [31:0] tbl_time [TableDepth];
  int          fill_count;
  logic [31:0] decay_period;
  logic [15:0] increment;
  dst_pkg::out_beat_t expected_beats [$];

  initial begin
    logic [63:0] acc;
    acc = 64'd1 << 32;
    decay_frac[0] = 17'd65536;
    for (int i = 1; i < 256; i++) begin
      acc = (acc * 64'd4283353945 + (64'd1 << 31)) >> 32;
      decay_frac[i] = 17'((acc + 64'd32768) >> 16);
    end
  end

  function automatic logic [31:0] decay_score(logic [31:0] score, logic [31:0] then_s,
                                              logic [31:0] now_s);
    longint      elapsed;
    logic [63:0] q, r, idx, s;
    elapsed = longint'({32'd0, now_s}) - longint'({32'd0, then_s});
    if (elapsed <= 0) return score;
    if (decay_period == 0) return 32'd0;
    q = 64'(elapsed) / decay_period;
    r = 64'(elapsed) % decay_period;
    if (q >= 64) return 32'd0;
    idx = (r << 8) / decay_period;
    s = {32'd0, score} >> q;
    return 32'((s * decay_frac[idx[7:0]]) >> 16);
  endfunction

  function automatic dst_pkg::out_beat_t apply_launch(dst_pkg::in_beat_t beat);
    dst_pkg::out_beat_t res;
    int          slot;
    logic        hit;
    logic [31:0] base, best, s;
    logic [32:0] sum;
    hit = 1'b0;
    slot = 0;
    base = 32'd0;
    for (int i = 0; i < fill_count; i++) begin
      if (!hit && tbl_key[i] == beat.key) begin
        hit = 1'b1;
        slot = i;
      end
    end
    if (hit) begin
      base = decay_score(tbl_score[slot], tbl_time[slot], beat.now_seconds);
      res.outcome = dst_pkg::OutcomeHit;
    end else if (fill_count < TableDepth) begin
      slot = fill_count;
      fill_count++;
      res.outcome = dst_pkg::OutcomeAppend;
    end else begin
      best = '0;
      for (int i = 0; i < TableDepth; i++) begin
        s = decay_score(tbl_score[i], tbl_time[i], beat.now_seconds);
        if (i == 0 || s < best) begin
          best = s;
          slot = i;
        end
      end
      res.outcome = dst_pkg::OutcomeEvict;
    end
    tbl_key[slot] = beat.key;
    sum = {1'b0, base} + {17'd0, increment};
    if (sum[32]) sum = {1'b0, ScoreMax};
    tbl_score[slot] = sum[31:0];
    tbl_time[slot] = beat.now_seconds;
    res.slot = slot[8:0];
    res.new_score = sum[31:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dst_pkg::out_beat_t want;
    if (!rst_ni) begin
      fill_count = 0;
      decay_period = dst_pkg::HalfLifeReset;
      increment = dst_pkg::IncrementReset;
      expected_beats.delete();
      failures_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i == dst_pkg::AddrHalfLife) decay_period = pwdata_i;
        else if (paddr_i == dst_pkg::AddrIncrement) increment = pwdata_i[15:0];
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          failures_o++;
          if (failures_o <= 10)
            $display("unexpected result beat slot=%0d outcome=%0d score=%h",
                     out_data_i.slot, out_data_i.outcome, out_data_i.new_score);
        end else begin
          want = expected_beats.pop_front();
          if (want.slot !== out_data_i.slot || want.outcome !== out_data_i.outcome ||
              want.new_score !== out_data_i.new_score) begin
            failures_o++;
            if (failures_o <= 10)
              $display("result mismatch: exp slot=%0d outcome=%0d score=%h, got %0d %0d %h",
                       want.slot, want.outcome, want.new_score, out_data_i.slot,
                       out_data_i.outcome, out_data_i.new_score);
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_beats.push_back(apply_launch(in_data_i));
    end
    pending_o = expected_beats.size();
  end
endmodule

// ===== tb/decaying_score_table_tb.sv =====
// Testbench top for decaying_score_table: clock, reset, launch and APB stimulus
// across idling phases, and the verdict. Depends on dst_pkg, dst_score_checker, the DUT.
`timescale 1ns / 1ps
module decaying_score_table_tb;
  localparam int CycleLimit = 60_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  dst_pkg::in_beat_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  dst_pkg::out_beat_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [dst_pkg::CfgAddrBits-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int pending;
  int failures;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  logic [31:0] clock_now = 32'd1000;
  logic [63:0] key_pool [32];

  always #6 clk_i = ~clk_i;

  decaying_score_table u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  dst_score_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready), .pending_o(pending), .failures_o(failures)
  );

  always @(negedge clk_i) out_ready_i = ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic launch(logic [63:0] key, logic [31:0] now_s);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i.key = key;
    in_data_i.now_seconds = now_s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic reg_write(logic [dst_pkg::CfgAddrBits-1:0] addr, logic [31:0] value);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Time mostly moves forward by up to a few half-lives, sometimes back or anywhere.
  function automatic logic [31:0] next_time(logic [31:0] span);
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) clock_now = clock_now - $urandom_range(0, 50);
    else if (roll < 13) clock_now = $urandom();
    else if (roll < 30) clock_now = clock_now;
    else clock_now = clock_now + $urandom_range(0, span);
    return clock_now;
  endfunction

  task automatic random_phase(int items, logic [31:0] span);
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(99) < 90) launch(key_pool[$urandom_range(31)], next_time(span));
      else launch({$urandom(), $urandom()}, next_time(span));
    end
    wait_idle();
  endtask

  task automatic fill_phase(int items);
    for (int i = 0; i < items; i++) launch({$urandom(), $urandom()}, next_time(32'd300));
  endtask

  initial begin
    for (int i = 0; i < 32; i++) key_pool[i] = {$urandom(), $urandom()};
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extreme keys and times, hit with no elapsed time, backwards time
    launch('0, 32'd0);
    launch('1, 32'hFFFF_FFFF);
    launch('0, 32'd0);
    launch('0, 32'd604800);
    launch('0, 32'd907200);
    launch('1, 32'd5);
    launch('1, 32'd10);
    wait_idle();
    reg_write(dst_pkg::AddrHalfLife, 32'd0);
    reg_write(dst_pkg::AddrIncrement, 32'd65535);
    launch('0, 32'd907200);
    launch('0, 32'd907201);
    launch('0, 32'd907201);
    wait_idle();
    reg_write(dst_pkg::AddrHalfLife, 32'd1);
    reg_write(dst_pkg::AddrIncrement, 32'd0);
    launch('0, 32'd907300);
    launch('0, 32'd907302);
    wait_idle();
    reg_write(dst_pkg::AddrIncrement, 32'd1);
    launch('0, 32'd907302);
    launch('1, 32'd1000);
    wait_idle();
    reg_write(dst_pkg::AddrHalfLife, 32'hFFFF_FFFF);
    reg_write(dst_pkg::AddrIncrement, 32'h0000_FFFF);
    launch('1, 32'd0);
    launch('1, 32'hFFFF_FFFF);
    wait_idle();

    reg_write(dst_pkg::AddrHalfLife, 32'd100);
    reg_write(dst_pkg::AddrIncrement, 32'd4096);
    random_phase(6, 400);
    send_idle_pct = 82;
    reg_write(dst_pkg::AddrHalfLife, 32'd7);
    reg_write(dst_pkg::AddrIncrement, 32'd40000);
    random_phase(6, 40);
    send_idle_pct = 0;
    stall_pct = 82;
    reg_write(dst_pkg::AddrHalfLife, 32'd604800);
    reg_write(dst_pkg::AddrIncrement, 32'd12345);
    random_phase(6, 2_000_000);
    send_idle_pct = 38;
    stall_pct = 38;
    reg_write(dst_pkg::AddrHalfLife, 32'd3);
    reg_write(dst_pkg::AddrIncrement, 32'd1);
    random_phase(6, 20);

    // fill the table with fresh keys across the idling phases, then mix hits and evictions
    send_idle_pct = 0;
    stall_pct = 0;
    reg_write(dst_pkg::AddrHalfLife, 32'd500);
    reg_write(dst_pkg::AddrIncrement, 32'd2000);
    fill_phase(128);
    send_idle_pct = 82;
    fill_phase(128);
    send_idle_pct = 0;
    stall_pct = 82;
    fill_phase(128);
    send_idle_pct = 38;
    stall_pct = 38;
    fill_phase(126);
    send_idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < 8; i++) begin
      if (i % 2 == 0) launch({$urandom(), $urandom()}, next_time(300));
      else launch(key_pool[$urandom_range(31)], next_time(300));
    end
    wait_idle();
    repeat (50) @(posedge clk_i);
    if (failures == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/dst_pkg.sv
rtl/dst_ram.sv
rtl/dst_datapath.sv
rtl/dst_ctrl.sv
rtl/decaying_score_table.sv
tb/dst_score_checker.sv
tb/decaying_score_table_tb.sv
